[src/lfr_pkg.sv]
// Package for the literal find-and-replace stream block.
// Word types, configuration register indexes and shared constants.
// No dependencies.
package lfr_pkg;

  localparam int LEN_W           = 4;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int DEF_MAX_PATTERN = 8;
  localparam int DEF_MAX_REPLACE = 8;
  localparam int JOBQ_DEPTH      = 2;

  localparam logic [7:0] NEWLINE = 8'd10;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_LEN  = 2'd0,
    CFG_SEARCH_PAT  = 2'd1,
    CFG_REPLACE_LEN = 2'd2,
    CFG_REPLACE_TXT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_word_t;

endpackage

[src/lfr_front.sv]
// Front end: configuration registers, match window and job builder.
// Turns each input word into at most one job of up to JOB_N output bytes.
// Depends on lfr_pkg.
module lfr_front import lfr_pkg::*; #(
  parameter  int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter  int MAX_REPLACE = DEF_MAX_REPLACE,
  localparam int JOB_N       = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE,
  localparam int JW          = $clog2(JOB_N + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  push,
  output logic                  full,
  input  in_word_t              in_word,
  output logic                  job_push,
  input  logic                  job_full,
  output logic [JOB_N-1:0][7:0] job_bytes,
  output logic [JW-1:0]         job_cnt
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int XW = LEN_W + 1;

  logic [LEN_W-1:0] slen_r;
  logic [CFG_W-1:0] spat_r;
  logic [LEN_W-1:0] rlen_r;
  logic [CFG_W-1:0] rtext_r;

  logic [7:0]       win_r   [MAX_PATTERN];
  logic [7:0]       win_nxt [MAX_PATTERN];
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             open_r, open_nxt;

  logic [LEN_W-1:0] len, rlen;
  logic             is_end, is_nl, hit, use_rep, accept;
  logic [7:0]       bsel;
  logic [7:0]       cand [JOB_N];
  logic [7:0]       rep  [JOB_N];
  logic [XW-1:0]    c5, l5, k5, e5;
  logic [CW-1:0]    sh;

  always_comb begin
    len = slen_r;
    if (slen_r == '0) begin
      len = LEN_W'(1);
    end else if (slen_r > LEN_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end
    rlen = (rlen_r > LEN_W'(MAX_REPLACE)) ? LEN_W'(MAX_REPLACE) : rlen_r;

    is_end = (in_word.cmd == CMD_END);
    is_nl  = !is_end && (in_word.data_byte == NEWLINE);
    bsel   = (is_end || is_nl) ? NEWLINE : in_word.data_byte;

    for (int i = 0; i < JOB_N; i++) begin
      cand[i] = bsel;
      rep[i]  = 8'd0;
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (CW'(i) < cnt_r) begin
        cand[i] = win_r[i];
      end
    end
    for (int i = 0; i < MAX_REPLACE; i++) begin
      rep[i] = rtext_r[8*i +: 8];
    end

    hit = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < len && cand[i] != spat_r[8*i +: 8]) begin
        hit = 1'b0;
      end
    end

    c5 = XW'(cnt_r);
    l5 = XW'(len);
    k5 = c5 - l5 + XW'(2);
    e5 = (k5 >= c5) ? c5 : k5;

    sh       = '0;
    use_rep  = 1'b0;
    job_cnt  = '0;
    cnt_nxt  = cnt_r;
    open_nxt = open_r;

    if (is_end) begin
      job_cnt  = JW'(cnt_r) + JW'(open_r);
      cnt_nxt  = '0;
      open_nxt = 1'b0;
    end else if (is_nl) begin
      job_cnt  = JW'(cnt_r) + JW'(1);
      cnt_nxt  = '0;
      open_nxt = 1'b0;
    end else begin
      open_nxt = 1'b1;
      if (c5 >= l5) begin
        sh      = CW'(e5);
        job_cnt = JW'(e5);
        cnt_nxt = cnt_r + CW'(1) - CW'(e5);
      end else if (c5 + XW'(1) < l5) begin
        cnt_nxt = cnt_r + CW'(1);
      end else if (hit) begin
        use_rep = 1'b1;
        job_cnt = JW'(rlen);
        cnt_nxt = '0;
      end else begin
        sh      = CW'(1);
        job_cnt = JW'(1);
      end
    end

    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i];
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if ((CW + 1)'(j) == (CW + 1)'(i) + (CW + 1)'(sh)) begin
          win_nxt[i] = cand[j];
        end
      end
    end

    for (int i = 0; i < JOB_N; i++) begin
      job_bytes[i] = use_rep ? rep[i] : cand[i];
    end
  end

  assign full     = job_full;
  assign accept   = push && !job_full;
  assign job_push = accept && (job_cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slen_r  <= LEN_W'(1);
      spat_r  <= '0;
      rlen_r  <= '0;
      rtext_r <= '0;
      cnt_r   <= '0;
      open_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SEARCH_LEN:  slen_r  <= cfg_wdata[LEN_W-1:0];
          CFG_SEARCH_PAT:  spat_r  <= cfg_wdata;
          CFG_REPLACE_LEN: rlen_r  <= cfg_wdata[LEN_W-1:0];
          CFG_REPLACE_TXT: rtext_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (accept) begin
        cnt_r  <= cnt_nxt;
        open_r <= open_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

[src/lfr_jobq.sv]
// Short job queue between the front end and the byte serializer.
// Accepts a push and a pop in the same cycle.
// Depends on lfr_pkg.
module lfr_jobq import lfr_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = JOBQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  output logic         q_full,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic         q_empty,
  output logic [W-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (num_r == NW'(DEPTH));
  assign q_empty = (num_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    num_nxt = num_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      num_nxt = num_r + NW'(1);
    end else if (do_rd && !do_wr) begin
      num_nxt = num_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      num_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      num_r <= num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

[src/lfr_back.sv]
// Back end: holds one job and hands out its bytes one word per pop.
// Marks the final byte of each job with last.
// Depends on lfr_pkg.
module lfr_back import lfr_pkg::*; #(
  parameter  int JOB_N = DEF_MAX_PATTERN,
  localparam int JW    = $clog2(JOB_N + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [JOB_N-1:0][7:0] q_bytes,
  input  logic [JW-1:0]         q_cnt,
  input  logic                  pop,
  output logic                  empty,
  output out_word_t             out_word
);

  localparam int IW = (JOB_N > 1) ? $clog2(JOB_N) : 1;

  logic                  valid_r;
  logic [JOB_N-1:0][7:0] bytes_r;
  logic [JW-1:0]         cnt_r;
  logic [IW-1:0]         idx_r;
  logic                  is_last, step, done, load;

  assign is_last = (JW'(idx_r) + JW'(1)) == cnt_r;
  assign step    = valid_r && pop;
  assign done    = step && is_last;
  assign load    = (!valid_r || done) && !q_empty;
  assign q_pop   = load;
  assign empty   = !valid_r;

  always_comb begin
    out_word.out_byte = bytes_r[idx_r];
    out_word.last     = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (done) begin
      valid_r <= 1'b0;
    end else if (step) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= q_bytes;
      cnt_r   <= q_cnt;
    end
  end

endmodule

[src/literal_find_replace_stream_top.sv]
// Top level of the streaming literal find-and-replace block.
// Instantiates lfr_front, lfr_jobq and lfr_back; depends on lfr_pkg.
//
//   Channel  Handshake          Payload
//   input    push / full        in_word  (cmd, data_byte)
//   result   empty / pop        out_word (out_byte, last)
//   config   cfg_we             cfg_idx, cfg_wdata
//
// The front end takes one word per cycle while full is low, builds any job from it combinationally
// and writes it into the job queue as the word is accepted. The back end delivers one byte per cycle
// while pop is high. The input stalls only while the two-entry job queue is full.
// Reset is synchronous: registers take their reset values and the window is empty.
module literal_find_replace_stream_top import lfr_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int MAX_REPLACE = DEF_MAX_REPLACE
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  in_word_t             in_word,
  output logic                 empty,
  input  logic                 pop,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int JOB_N = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
  localparam int JW    = $clog2(JOB_N + 1);
  localparam int QW    = JOB_N * 8 + JW;

  logic                  job_push, job_full, q_empty, q_pop;
  logic [JOB_N-1:0][7:0] job_bytes, q_bytes;
  logic [JW-1:0]         job_cnt, q_cnt;

  lfr_front #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_REPLACE(MAX_REPLACE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .job_push (job_push),
    .job_full (job_full),
    .job_bytes(job_bytes),
    .job_cnt  (job_cnt)
  );

  lfr_jobq #(
    .W    (QW),
    .DEPTH(JOBQ_DEPTH)
  ) u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .q_full (job_full),
    .wr_data({job_cnt, job_bytes}),
    .rd_en  (q_pop),
    .q_empty(q_empty),
    .rd_data({q_cnt, q_bytes})
  );

  lfr_back #(
    .JOB_N(JOB_N)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_bytes (q_bytes),
    .q_cnt   (q_cnt),
    .pop     (pop),
    .empty   (empty),
    .out_word(out_word)
  );

endmodule
